@@ rtl/kla_pkg.sv @@
// shared constants, codes and structs of the keyed lru cache admission block
// no dependencies
package kla_pkg;

    localparam int CACHE_ENTRIES_DEF = 8;
    localparam int PENDING_SLOTS_DEF = 64;

    localparam logic [2:0] REQ_LOOKUP    = 3'd0;
    localparam logic [2:0] REQ_BEGIN     = 3'd1;
    localparam logic [2:0] REQ_FINISH    = 3'd2;
    localparam logic [2:0] REQ_INVAL     = 3'd3;
    localparam logic [2:0] REQ_RESET_ALL = 3'd4;

    localparam logic [2:0] OUT_OK      = 3'd0;
    localparam logic [2:0] OUT_MISS    = 3'd1;
    localparam logic [2:0] OUT_RANGE   = 3'd2;
    localparam logic [2:0] OUT_BUSY    = 3'd3;
    localparam logic [2:0] OUT_BLOCKED = 3'd4;
    localparam logic [2:0] OUT_ARMED   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_BEGIN_CHK,
        ST_SCAN,
        ST_DECIDE,
        ST_FIN_DO,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [7:0]  key;
        logic [15:0] org_x;
        logic [15:0] org_y;
        logic [31:0] stamp;
    } tag_word_t;

    typedef struct packed {
        logic        clr_all;
        logic        arm;
        logic        clr;
        logic        block;
        logic [7:0]  idx;
        logic [15:0] org_x;
        logic [15:0] org_y;
    } pend_cmd_t;

    typedef struct packed {
        logic        armed;
        logic        blocked;
        logic [15:0] org_x;
        logic [15:0] org_y;
    } pend_rd_t;

endpackage

@@ rtl/kla_tag_ram.sv @@
// tag memory: key, origin and lru stamp of every cache entry
// one write port, one registered read port; uses kla_pkg
module kla_tag_ram #(
    parameter int CACHE_ENTRIES = kla_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(CACHE_ENTRIES)-1:0] waddr,
    input  kla_pkg::tag_word_t               wdata,
    input  logic [$clog2(CACHE_ENTRIES)-1:0] raddr,
    output kla_pkg::tag_word_t               rdata
);

    kla_pkg::tag_word_t mem [0:CACHE_ENTRIES-1];
    kla_pkg::tag_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/kla_pend_table.sv @@
// pending admission table: armed and blocked bits per slot, first-touch origin
// origin store is a memory with registered read; uses kla_pkg
module kla_pend_table #(
    parameter int PENDING_SLOTS = kla_pkg::PENDING_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kla_pkg::pend_cmd_t cmd,
    input  logic [7:0]         rd_slot,
    output kla_pkg::pend_rd_t  rd
);

    localparam int PW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    logic [PENDING_SLOTS-1:0] armed_reg;
    logic [PENDING_SLOTS-1:0] blocked_reg;
    logic [15:0]              org_x_mem [0:PENDING_SLOTS-1];
    logic [15:0]              org_y_mem [0:PENDING_SLOTS-1];
    logic [15:0]              org_x_q_reg;
    logic [15:0]              org_y_q_reg;
    logic [PW-1:0]            wi;
    logic [PW-1:0]            ri;

    assign wi = cmd.idx[PW-1:0];
    assign ri = rd_slot[PW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= '0;
            blocked_reg <= '0;
        end
        else if (cmd.clr_all)
        begin
            armed_reg   <= '0;
            blocked_reg <= '0;
        end
        else if (cmd.arm)
        begin
            armed_reg[wi] <= 1'b1;
        end
        else if (cmd.clr)
        begin
            armed_reg[wi]   <= 1'b0;
            blocked_reg[wi] <= 1'b0;
        end
        else if (cmd.block)
        begin
            armed_reg[wi]   <= 1'b0;
            blocked_reg[wi] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.arm && !cmd.clr_all)
        begin
            org_x_mem[wi] <= cmd.org_x;
            org_y_mem[wi] <= cmd.org_y;
        end
        org_x_q_reg <= org_x_mem[ri];
        org_y_q_reg <= org_y_mem[ri];
    end

    assign rd.armed   = armed_reg[ri];
    assign rd.blocked = blocked_reg[ri];
    assign rd.org_x   = org_x_q_reg;
    assign rd.org_y   = org_y_q_reg;

endmodule

@@ rtl/kla_seq.sv @@
// request sequencer: entry walk with one shared key and stamp compare,
// entry used/valid bits, lru clock, open recording and result register; uses kla_pkg
module kla_seq #(
    parameter int CACHE_ENTRIES = kla_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_SLOTS = kla_pkg::PENDING_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       req_type,
    input  logic [7:0]                       slot,
    input  logic signed [15:0]               origin_x,
    input  logic signed [15:0]               origin_y,
    input  logic [2:0]                       entry_index,
    input  logic                             entry_given,
    input  logic                             build_ok,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       outcome,
    output logic [2:0]                       entry_index_res,
    output logic                             evicted,
    output logic                             tag_we,
    output logic [$clog2(CACHE_ENTRIES)-1:0] tag_waddr,
    output kla_pkg::tag_word_t               tag_wdata,
    output logic [$clog2(CACHE_ENTRIES)-1:0] tag_raddr,
    input  kla_pkg::tag_word_t               tag_rdata,
    output kla_pkg::pend_cmd_t               pend_cmd,
    output logic [7:0]                       pend_slot,
    input  kla_pkg::pend_rd_t                pend_rd
);

    localparam int EW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(CACHE_ENTRIES + 1);

    kla_pkg::state_t state_reg, state_next;

    logic [2:0]  req_reg, req_next;
    logic [7:0]  slot_reg, slot_next;
    logic [15:0] ox_reg, ox_next;
    logic [15:0] oy_reg, oy_next;
    logic [2:0]  ei_reg, ei_next;
    logic        given_reg, given_next;
    logic        ok_reg, ok_next;

    logic [CACHE_ENTRIES-1:0] used_reg, used_next;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]              lru_reg, lru_next;
    logic                     rec_open_reg, rec_open_next;
    logic [EW-1:0]            rec_entry_reg, rec_entry_next;

    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          cmp_en_reg, cmp_en_next;
    logic [EW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          hit_found_reg, hit_found_next;
    logic [EW-1:0] hit_idx_reg, hit_idx_next;
    logic          hit_org_reg, hit_org_next;
    logic          free_found_reg, free_found_next;
    logic [EW-1:0] free_idx_reg, free_idx_next;
    logic [EW-1:0] min_idx_reg, min_idx_next;
    logic [31:0]   min_stamp_reg, min_stamp_next;

    logic [2:0]    res_outc_reg, res_outc_next;
    logic [EW-1:0] res_idx_reg, res_idx_next;
    logic          res_ev_reg, res_ev_next;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    outcome_reg, outcome_next;
    logic [2:0]    out_idx_reg, out_idx_next;
    logic          evicted_reg, evicted_next;

    logic          slot_in_range;
    logic          ei_in_range;
    logic          key_in_range;
    logic [EW-1:0] ei_idx;
    logic [EW-1:0] pick;
    logic [31:0]   stamp_new;

    assign slot_in_range = ({1'b0, slot_reg} < 9'(PENDING_SLOTS));
    assign ei_in_range   = (7'(ei_reg) < 7'(CACHE_ENTRIES));
    assign key_in_range  = ({1'b0, tag_rdata.key} < 9'(PENDING_SLOTS));
    assign ei_idx        = EW'(ei_reg);
    assign stamp_new     = lru_reg + 32'd1;
    assign pick          = hit_found_reg ? hit_idx_reg :
                           (free_found_reg ? free_idx_reg : min_idx_reg);

    assign in_ready        = (state_reg == kla_pkg::ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign outcome         = outcome_reg;
    assign entry_index_res = out_idx_reg;
    assign evicted         = evicted_reg;
    assign pend_slot       = slot_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        slot_next       = slot_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        ei_next         = ei_reg;
        given_next      = given_reg;
        ok_next         = ok_reg;
        used_next       = used_reg;
        valid_next      = valid_reg;
        lru_next        = lru_reg;
        rec_open_next   = rec_open_reg;
        rec_entry_next  = rec_entry_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_en_next     = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_org_next    = hit_org_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        min_idx_next    = min_idx_reg;
        min_stamp_next  = min_stamp_reg;
        res_outc_next   = res_outc_reg;
        res_idx_next    = res_idx_reg;
        res_ev_next     = res_ev_reg;
        out_valid_next  = out_valid_reg;
        outcome_next    = outcome_reg;
        out_idx_next    = out_idx_reg;
        evicted_next    = evicted_reg;

        tag_we          = 1'b0;
        tag_waddr       = pick;
        tag_wdata.key   = slot_reg;
        tag_wdata.org_x = ox_reg;
        tag_wdata.org_y = oy_reg;
        tag_wdata.stamp = stamp_new;
        tag_raddr       = scan_cnt_reg[EW-1:0];
        pend_cmd         = '0;
        pend_cmd.idx     = slot_reg;
        pend_cmd.org_x   = ox_reg;
        pend_cmd.org_y   = oy_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // shared compare stage of the entry walk
        if (cmp_en_reg)
        begin
            if (used_reg[cmp_idx_reg] && tag_rdata.key == slot_reg && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = cmp_idx_reg;
                hit_org_next   = (tag_rdata.org_x == ox_reg) && (tag_rdata.org_y == oy_reg);
            end
            if (!used_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
            if (cmp_idx_reg == '0 || tag_rdata.stamp < min_stamp_reg)
            begin
                min_idx_next   = cmp_idx_reg;
                min_stamp_next = tag_rdata.stamp;
            end
        end

        case (state_reg)
            kla_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    slot_next  = slot;
                    ox_next    = origin_x;
                    oy_next    = origin_y;
                    ei_next    = entry_index;
                    given_next = entry_given;
                    ok_next    = build_ok;
                    state_next = kla_pkg::ST_DISPATCH;
                end
            end
            kla_pkg::ST_DISPATCH:
            begin
                res_outc_next   = kla_pkg::OUT_OK;
                res_idx_next    = '0;
                res_ev_next     = 1'b0;
                scan_cnt_next   = '0;
                hit_found_next  = 1'b0;
                free_found_next = 1'b0;
                tag_raddr       = ei_idx;
                case (req_reg)
                    kla_pkg::REQ_LOOKUP:
                    begin
                        if (!slot_in_range)
                        begin
                            res_outc_next = kla_pkg::OUT_RANGE;
                            state_next    = kla_pkg::ST_RESULT;
                        end
                        else
                        begin
                            state_next = kla_pkg::ST_SCAN;
                        end
                    end
                    kla_pkg::REQ_BEGIN:
                    begin
                        if (!slot_in_range)
                        begin
                            res_outc_next = kla_pkg::OUT_RANGE;
                            state_next    = kla_pkg::ST_RESULT;
                        end
                        else if (rec_open_reg)
                        begin
                            res_outc_next = kla_pkg::OUT_BUSY;
                            state_next    = kla_pkg::ST_RESULT;
                        end
                        else if (pend_rd.blocked)
                        begin
                            res_outc_next = kla_pkg::OUT_BLOCKED;
                            state_next    = kla_pkg::ST_RESULT;
                        end
                        else
                        begin
                            state_next = kla_pkg::ST_BEGIN_CHK;
                        end
                    end
                    kla_pkg::REQ_FINISH:
                    begin
                        if (given_reg && ei_in_range)
                        begin
                            state_next = kla_pkg::ST_FIN_DO;
                        end
                        else
                        begin
                            state_next = kla_pkg::ST_RESULT;
                        end
                    end
                    kla_pkg::REQ_INVAL:
                    begin
                        state_next = kla_pkg::ST_SCAN;
                    end
                    kla_pkg::REQ_RESET_ALL:
                    begin
                        used_next        = '0;
                        valid_next       = '0;
                        rec_open_next    = 1'b0;
                        pend_cmd.clr_all = 1'b1;
                        state_next       = kla_pkg::ST_RESULT;
                    end
                    default:
                    begin
                        state_next = kla_pkg::ST_RESULT;
                    end
                endcase
            end
            kla_pkg::ST_BEGIN_CHK:
            begin
                if (!pend_rd.armed || pend_rd.org_x != ox_reg || pend_rd.org_y != oy_reg)
                begin
                    pend_cmd.arm  = 1'b1;
                    res_outc_next = kla_pkg::OUT_ARMED;
                    state_next    = kla_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = kla_pkg::ST_SCAN;
                end
            end
            kla_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg == CW'(CACHE_ENTRIES))
                begin
                    state_next = kla_pkg::ST_DECIDE;
                end
                else
                begin
                    cmp_en_next   = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[EW-1:0];
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
            end
            kla_pkg::ST_DECIDE:
            begin
                state_next = kla_pkg::ST_RESULT;
                case (req_reg)
                    kla_pkg::REQ_LOOKUP:
                    begin
                        if (hit_found_reg && valid_reg[hit_idx_reg] && hit_org_reg)
                        begin
                            tag_we       = 1'b1;
                            lru_next     = stamp_new;
                            res_idx_next = hit_idx_reg;
                        end
                        else
                        begin
                            res_outc_next = kla_pkg::OUT_MISS;
                        end
                    end
                    kla_pkg::REQ_BEGIN:
                    begin
                        tag_we            = 1'b1;
                        used_next[pick]   = 1'b1;
                        valid_next[pick]  = 1'b0;
                        lru_next          = stamp_new;
                        rec_open_next     = 1'b1;
                        rec_entry_next    = pick;
                        res_idx_next      = pick;
                        res_ev_next       = !hit_found_reg && !free_found_reg;
                    end
                    kla_pkg::REQ_INVAL:
                    begin
                        if (hit_found_reg)
                        begin
                            used_next[hit_idx_reg]  = 1'b0;
                            valid_next[hit_idx_reg] = 1'b0;
                            if (rec_open_reg && rec_entry_reg == hit_idx_reg)
                            begin
                                rec_open_next = 1'b0;
                            end
                        end
                        pend_cmd.clr = slot_in_range;
                    end
                    default:
                    begin
                        res_outc_next = kla_pkg::OUT_OK;
                    end
                endcase
            end
            kla_pkg::ST_FIN_DO:
            begin
                state_next = kla_pkg::ST_RESULT;
                if (rec_open_reg && rec_entry_reg == ei_idx)
                begin
                    rec_open_next = 1'b0;
                end
                if (ok_reg)
                begin
                    valid_next[ei_idx] = 1'b1;
                end
                else
                begin
                    pend_cmd.idx       = tag_rdata.key;
                    pend_cmd.block     = used_reg[ei_idx] && key_in_range;
                    used_next[ei_idx]  = 1'b0;
                    valid_next[ei_idx] = 1'b0;
                end
            end
            kla_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    outcome_next   = res_outc_reg;
                    out_idx_next   = 3'(res_idx_reg);
                    evicted_next   = res_ev_reg;
                    state_next     = kla_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kla_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kla_pkg::ST_IDLE;
            used_reg      <= '0;
            valid_reg     <= '0;
            lru_reg       <= '0;
            rec_open_reg  <= 1'b0;
            rec_entry_reg <= '0;
            scan_cnt_reg  <= '0;
            cmp_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            valid_reg     <= valid_next;
            lru_reg       <= lru_next;
            rec_open_reg  <= rec_open_next;
            rec_entry_reg <= rec_entry_next;
            scan_cnt_reg  <= scan_cnt_next;
            cmp_en_reg    <= cmp_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        slot_reg       <= slot_next;
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        ei_reg         <= ei_next;
        given_reg      <= given_next;
        ok_reg         <= ok_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_org_reg    <= hit_org_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        min_idx_reg    <= min_idx_next;
        min_stamp_reg  <= min_stamp_next;
        res_outc_reg   <= res_outc_next;
        res_idx_reg    <= res_idx_next;
        res_ev_reg     <= res_ev_next;
        outcome_reg    <= outcome_next;
        out_idx_reg    <= out_idx_next;
        evicted_reg    <= evicted_next;
    end

endmodule

@@ rtl/keyed_lru_cache_admission.sv @@
// top level of the keyed lru cache admission block
// instantiates kla_seq, kla_tag_ram and kla_pend_table; uses kla_pkg
//
// channel   direction  handshake             payload
// request   in         in_valid / in_ready   req_type slot origin_x origin_y
//                                            entry_index entry_given build_ok
// result    out        out_valid / out_ready outcome entry_index_res evicted
//
// lookup and invalidate walk every tag entry before the next request can transfer,
// a granted begin also passes the begin check; the walk reads one tag entry per
// cycle through a single compare unit; finish, reset all and early rejects skip it.
// after reset the block is ready at once, with no clearing pass.
// a held result stalls only the next request's final result step.
module keyed_lru_cache_admission #(
    parameter int CACHE_ENTRIES = kla_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_SLOTS = kla_pkg::PENDING_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [7:0]         slot,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic [2:0]         entry_index,
    input  logic               entry_given,
    input  logic               build_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         outcome,
    output logic [2:0]         entry_index_res,
    output logic               evicted
);

    localparam int EW = $clog2(CACHE_ENTRIES);

    logic               tag_we;
    logic [EW-1:0]      tag_waddr;
    kla_pkg::tag_word_t tag_wdata;
    logic [EW-1:0]      tag_raddr;
    kla_pkg::tag_word_t tag_rdata;
    kla_pkg::pend_cmd_t pend_cmd;
    logic [7:0]         pend_slot;
    kla_pkg::pend_rd_t  pend_rd;

    kla_seq #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .PENDING_SLOTS (PENDING_SLOTS)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .slot            (slot),
        .origin_x        (origin_x),
        .origin_y        (origin_y),
        .entry_index     (entry_index),
        .entry_given     (entry_given),
        .build_ok        (build_ok),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .outcome         (outcome),
        .entry_index_res (entry_index_res),
        .evicted         (evicted),
        .tag_we          (tag_we),
        .tag_waddr       (tag_waddr),
        .tag_wdata       (tag_wdata),
        .tag_raddr       (tag_raddr),
        .tag_rdata       (tag_rdata),
        .pend_cmd        (pend_cmd),
        .pend_slot       (pend_slot),
        .pend_rd         (pend_rd)
    );

    kla_tag_ram #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    kla_pend_table #(
        .PENDING_SLOTS (PENDING_SLOTS)
    ) u_pend_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (pend_cmd),
        .rd_slot (pend_slot),
        .rd      (pend_rd)
    );

`ifndef SYNTHESIS
    // busy right after a request transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a request back to back");

    // only defined outcome codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outcome <= kla_pkg::OUT_ARMED))
        else $error("undefined outcome code");

    // eviction only on a granted begin
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> outcome == kla_pkg::OUT_OK)
        else $error("eviction flagged without a grant");
`endif

endmodule
